[src/assert_macros.svh]
// Assertion macros for the RTL.
// ASSERT_IMP checks a same-cycle implication, ASSERT_NXT a next-cycle one.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/llre_pkg.sv]
package llre_pkg;

    localparam int MAX_BALLS = 64;
    localparam int BALL_W    = 7;
    localparam int ADDR_W    = $clog2(MAX_BALLS);

    typedef logic [BALL_W-1:0] ball_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        OP_RESTART    = 2'd0,
        OP_MOVE_LEFT  = 2'd1,
        OP_MOVE_RIGHT = 2'd2,
        OP_REPORT     = 2'd3
    } op_t;

    // Registered read result of a link table
    typedef struct packed {
        ball_t word;
        logic  hit;
        addr_t addr;
    } link_rd_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic restart;
        logic rd_x;
        logic unlink;
        logic link1;
        logic link2;
        logic rpt_start;
        logic rpt_rd;
        logic rpt_next;
    } llre_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic move_ok;
        logic rpt_last;
    } llre_status_t;

    // Ball number to table address (ball b lives at b-1)
    function automatic addr_t ball_addr(input ball_t b);
        ball_t d;
        d = b - ball_t'(1);
        return d[ADDR_W-1:0];
    endfunction

endpackage

[src/linked_list_reorder_engine.sv]
// Reorder engine for a line of numbered balls held as a doubly linked list.
// Input stream s_*: one transfer carries op, ball_x and ball_y. op restart
// rebuilds the order 1..ball_count, move left/right relinks ball_x next to
// ball_y (moves with a ball out of range or ball_x equal to ball_y are
// dropped), report streams the whole order on m_*, one ball per transfer,
// with m_tlast on the final ball.
// cfg_we/cfg_data write ball_count (saturated to 2..64) and rebuild the order.
// One item is in work at a time; s_tready is high only while idle.
// Each item first passes through dispatch; a valid move then reads the links
// of x, unlinks x and relinks it, a restart or dropped move ends there. Each
// reported ball costs one registered read of the right-link table and one
// output transfer; a move is bound by its chain of dependent link reads and
// writes on the two tables.
// Reset sets ball_count to 64 and the order 1..64 at once (per-entry valid
// bits stand in for the rebuilt chain), so no clearing pass is needed.
// While m_tready is low the current ball is held and the walk pauses.
module linked_list_reorder_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[1:0], ball_x[8:2], ball_y[15:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // ball[6:0], zero[7]
    output logic        m_tlast
);
    import llre_pkg::*;

    llre_cmd_t    cmd;
    llre_status_t status;
    ball_t        out_ball;

    llre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    llre_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_op    (op_t'(s_tdata[1:0])),
        .in_x     (s_tdata[8:2]),
        .in_y     (s_tdata[15:9]),
        .cmd      (cmd),
        .status   (status),
        .out_ball (out_ball),
        .out_last (m_tlast)
    );

    assign m_tdata = {1'b0, out_ball};

`include "assert_macros.svh"

    // Input and output never open together: one item in work at a time
    `ASSERT_IMP(a_one_item, clk, rst_n, s_tready, !m_tvalid)
    // An accepted item always goes through dispatch first
    `ASSERT_NXT(a_dispatch, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // More balls follow a transfer without tlast
    `ASSERT_NXT(a_walk_on, clk, rst_n, m_tvalid && m_tready && !m_tlast, !s_tready)
    // Reported balls are never the left end mark
    `ASSERT_IMP(a_ball_nonzero, clk, rst_n, m_tvalid, m_tdata[6:0] != 7'd0)

endmodule

[src/llre_link_table.sv]
module llre_link_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  logic           rd_en,
    input  llre_pkg::addr_t rd_addr,
    input  logic           wr_en,
    input  llre_pkg::addr_t wr_addr,
    input  llre_pkg::ball_t wr_data,
    output llre_pkg::link_rd_t rd
);
    import llre_pkg::*;

    ball_t                 mem [MAX_BALLS];
    logic [MAX_BALLS-1:0]  valid_reg;
    ball_t                 rd_word_reg;
    logic                  rd_hit_reg;
    addr_t                 rd_addr_reg;

    // Per-entry valid bits; an unwritten entry reads as the rebuilt chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    assign rd.word = rd_word_reg;
    assign rd.hit  = rd_hit_reg;
    assign rd.addr = rd_addr_reg;

endmodule

[src/llre_datapath.sv]
module llre_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  llre_pkg::ball_t      cfg_data,
    input  llre_pkg::op_t        in_op,
    input  llre_pkg::ball_t      in_x,
    input  llre_pkg::ball_t      in_y,
    input  llre_pkg::llre_cmd_t  cmd,
    output llre_pkg::llre_status_t status,
    output llre_pkg::ball_t      out_ball,
    output logic                 out_last
);
    import llre_pkg::*;

    localparam logic [ADDR_W-1:0] CNT_ONE = ADDR_W'(1);

    ball_t              count_reg, count_next;
    ball_t              head_reg, head_next;
    op_t                op_reg;
    ball_t              x_reg, y_reg;
    ball_t              lx_reg, rx_reg;
    ball_t              cur_reg;
    logic [ADDR_W-1:0]  cnt_reg;

    ball_t              end_mark;
    ball_t              ldata, rdata, nb;
    logic               clear;
    logic               is_left;
    link_rd_t           l_rd, r_rd;

    logic               l_rd_en, r_rd_en, l_wr_en, r_wr_en;
    addr_t              l_rd_addr, r_rd_addr, l_wr_addr, r_wr_addr;
    ball_t              l_wr_data, r_wr_data;

    assign end_mark = count_reg + ball_t'(1);
    assign clear    = cmd.restart | cfg_we;
    assign is_left  = (op_reg == OP_MOVE_LEFT);

    // Table reads with the rebuilt-chain value for unwritten entries
    assign ldata = l_rd.hit ? l_rd.word : ball_t'({1'b0, l_rd.addr});
    assign rdata = r_rd.hit ? r_rd.word : ball_t'({1'b0, r_rd.addr}) + ball_t'(2);

    // Neighbor of y after the unlink, patched for the write that raced the read
    always_comb
    begin
        if (is_left)
        begin
            nb = (rx_reg == y_reg) ? lx_reg : ldata;
        end
        else
        begin
            nb = (lx_reg == y_reg) ? rx_reg : rdata;
        end
    end

    // Read ports
    always_comb
    begin
        l_rd_en   = cmd.rd_x | (cmd.unlink & is_left);
        l_rd_addr = cmd.rd_x ? ball_addr(x_reg) : ball_addr(y_reg);
        r_rd_en   = cmd.rd_x | (cmd.unlink & !is_left) | cmd.rpt_rd;
        if (cmd.rd_x)
        begin
            r_rd_addr = ball_addr(x_reg);
        end
        else if (cmd.rpt_rd)
        begin
            r_rd_addr = ball_addr(cur_reg);
        end
        else
        begin
            r_rd_addr = ball_addr(y_reg);
        end
    end

    // Write ports: unlink, then two steps of relinking
    always_comb
    begin
        l_wr_en   = 1'b0;
        l_wr_addr = ball_addr(x_reg);
        l_wr_data = x_reg;
        r_wr_en   = 1'b0;
        r_wr_addr = ball_addr(x_reg);
        r_wr_data = x_reg;
        if (cmd.unlink)
        begin
            r_wr_en   = (ldata != '0);
            r_wr_addr = ball_addr(ldata);
            r_wr_data = rdata;
            l_wr_en   = (rdata != end_mark);
            l_wr_addr = ball_addr(rdata);
            l_wr_data = ldata;
        end
        else if (cmd.link1)
        begin
            l_wr_en   = 1'b1;
            l_wr_addr = ball_addr(x_reg);
            l_wr_data = is_left ? nb : y_reg;
            r_wr_en   = 1'b1;
            r_wr_addr = ball_addr(x_reg);
            r_wr_data = is_left ? y_reg : nb;
        end
        else if (cmd.link2)
        begin
            l_wr_en   = is_left ? 1'b1 : (nb != end_mark);
            l_wr_addr = is_left ? ball_addr(y_reg) : ball_addr(nb);
            l_wr_data = x_reg;
            r_wr_en   = is_left ? (nb != '0) : 1'b1;
            r_wr_addr = is_left ? ball_addr(nb) : ball_addr(y_reg);
            r_wr_data = x_reg;
        end
    end

    llre_link_table u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_en   (l_rd_en),
        .rd_addr (l_rd_addr),
        .wr_en   (l_wr_en),
        .wr_addr (l_wr_addr),
        .wr_data (l_wr_data),
        .rd      (l_rd)
    );

    llre_link_table u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_en   (r_rd_en),
        .rd_addr (r_rd_addr),
        .wr_en   (r_wr_en),
        .wr_addr (r_wr_addr),
        .wr_data (r_wr_data),
        .rd      (r_rd)
    );

    // Ball count with saturation, head of the line tracking
    always_comb
    begin
        count_next = count_reg;
        if (cfg_we)
        begin
            if (cfg_data < ball_t'(2))
            begin
                count_next = ball_t'(2);
            end
            else if (cfg_data > ball_t'(MAX_BALLS))
            begin
                count_next = ball_t'(MAX_BALLS);
            end
            else
            begin
                count_next = cfg_data;
            end
        end

        head_next = head_reg;
        if (clear)
        begin
            head_next = ball_t'(1);
        end
        else if (cmd.unlink && ldata == '0)
        begin
            head_next = rdata;
        end
        else if (cmd.link2 && is_left && nb == '0)
        begin
            head_next = x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= ball_t'(MAX_BALLS);
            head_reg  <= ball_t'(1);
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // Item fields, unlink neighbors and report walk position
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op;
            x_reg  <= in_x;
            y_reg  <= in_y;
        end
        if (cmd.unlink)
        begin
            lx_reg <= ldata;
            rx_reg <= rdata;
        end
        if (cmd.rpt_start)
        begin
            cur_reg <= head_reg;
            cnt_reg <= '0;
        end
        else if (cmd.rpt_next)
        begin
            cur_reg <= rdata;
            cnt_reg <= cnt_reg + CNT_ONE;
        end
    end

    assign status.op       = op_reg;
    assign status.move_ok  = (x_reg != '0) && (x_reg <= count_reg) &&
                             (y_reg != '0) && (y_reg <= count_reg) &&
                             (x_reg != y_reg);
    assign status.rpt_last = (ball_t'({1'b0, cnt_reg}) == count_reg - ball_t'(1));

    assign out_ball = cur_reg;
    assign out_last = status.rpt_last;

endmodule

[src/llre_ctrl.sv]
module llre_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  llre_pkg::llre_status_t status,
    output llre_pkg::llre_cmd_t    cmd
);
    import llre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_UNLINK,
        ST_LINK1,
        ST_LINK2,
        ST_RPT_RD,
        ST_RPT_OUT
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    OP_RESTART:
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    OP_REPORT:
                    begin
                        cmd.rpt_start = 1'b1;
                        state_next    = ST_RPT_RD;
                    end
                    default:
                    begin
                        if (status.move_ok)
                        begin
                            cmd.rd_x   = 1'b1;
                            state_next = ST_UNLINK;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = ST_LINK1;
            end
            ST_LINK1:
            begin
                cmd.link1  = 1'b1;
                state_next = ST_LINK2;
            end
            ST_LINK2:
            begin
                cmd.link2  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RPT_RD:
            begin
                cmd.rpt_rd = 1'b1;
                state_next = ST_RPT_OUT;
            end
            ST_RPT_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.rpt_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rpt_next = 1'b1;
                        state_next   = ST_RPT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
